// ===== rtl/core/tldq_pkg.sv =====
// shared constants and types for the two-level dedup request queue
package tldq_pkg;

    localparam int HIGH_DEPTH_DEF    = 64;
    localparam int LOW_DEPTH_DEF     = 64;
    localparam int PENDING_DEPTH_DEF = 128;

    localparam int ID_W    = 31;
    localparam int LIMIT_W = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;

    typedef enum logic [1:0] {
        KIND_ADD_HIGH = 2'd0,
        KIND_ADD_LOW  = 2'd1,
        KIND_TAKE     = 2'd2,
        KIND_RELEASE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic            accepted;
        logic            moved_up;
        logic [ID_W-1:0] next_id;
    } rsp_t;

endpackage

// ===== rtl/core/tldq_if.sv =====
// valid/ready channel interfaces for requests, responses and configuration
interface tldq_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] user_id;
    modport source (output valid, output kind, output user_id, input ready);
    modport sink   (input valid, input kind, input user_id, output ready);
endinterface

interface tldq_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic                     moved_up;
    logic [tldq_pkg::ID_W-1:0] next_id;
    modport source (output valid, output accepted, output moved_up, output next_id,
                    input ready);
    modport sink   (input valid, input accepted, input moved_up, input next_id,
                    output ready);
endinterface

interface tldq_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tldq_pkg::LIMIT_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/two_level_dedup_request_queue.sv =====
// top level: two-priority work queue with a duplicate filter over a pending set
//
// One request is handled at a time by a small sequencer. The pending set is a
// memory scanned one slot per cycle to find the id and the first free slot,
// and an add or release is decided once the whole set has been scanned. A
// high add of a pending id then scans the low queue entry by entry and, on a
// move, closes the gap by copying each later entry down by one place. The
// queues are circular buffers, so a take reads the head entries and moves no
// other entry. Pending valid bits are flip-flops cleared by reset; the id
// memories need no clearing. The next request is taken only once the response
// has been handed over on the response channel.
module two_level_dedup_request_queue #(
    parameter int HIGH_DEPTH    = tldq_pkg::HIGH_DEPTH_DEF,
    parameter int LOW_DEPTH     = tldq_pkg::LOW_DEPTH_DEF,
    parameter int PENDING_DEPTH = tldq_pkg::PENDING_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tldq_req_if.sink   req,
    tldq_rsp_if.source rsp,
    tldq_cfg_if.sink   cfg
);
    localparam int HA = $clog2(HIGH_DEPTH);
    localparam int LA = $clog2(LOW_DEPTH);
    localparam int PA = $clog2(PENDING_DEPTH);
    localparam int ID_W = tldq_pkg::ID_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_LSCAN, S_LCHK, S_SHIFT_RD, S_SHIFT_WR,
        S_TAKE_RD, S_TAKE_WAIT, S_RESP
    } state_t;

    // memories
    logic [ID_W-1:0] high_mem [HIGH_DEPTH];
    logic [ID_W-1:0] low_mem  [LOW_DEPTH];
    logic [ID_W-1:0] pend_mem [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] pvalid_reg;

    state_t state_reg;
    logic [1:0]       kind_reg;
    logic [ID_W-1:0]  id_reg;
    logic             id_ok_reg;
    logic [LA:0]      low_count_reg;
    logic [HA:0]      high_count_reg;
    logic [HA-1:0]    high_head_reg;
    logic [LA-1:0]    low_head_reg;
    logic [tldq_pkg::LIMIT_W-1:0] limit_reg;

    logic [PA:0]      pidx_reg;      // scan counter over the pending set
    logic             found_reg;
    logic [PA-1:0]    found_slot_reg;
    logic             free_reg;
    logic [PA-1:0]    free_slot_reg;
    logic [ID_W-1:0]  prd_reg;       // registered pending read
    logic             prd_vld_reg;
    logic [PA-1:0]    prd_slot_reg;

    logic [LA:0]      lidx_reg;      // scan position in the low queue
    logic [ID_W-1:0]  lrd_reg;       // registered low queue read
    logic [ID_W-1:0]  hrd_reg;       // registered high queue read

    logic             out_vld_reg;
    tldq_pkg::rsp_t   out_reg;

    // physical low queue address of logical position
    function automatic logic [LA-1:0] lphys(input logic [LA-1:0] head,
                                            input logic [LA:0] pos);
        logic [LA:0] s;
        s = {1'b0, head} + pos;
        if (s >= (LA+1)'(LOW_DEPTH)) s = s - (LA+1)'(LOW_DEPTH);
        return s[LA-1:0];
    endfunction

    function automatic logic [HA-1:0] hphys(input logic [HA-1:0] head,
                                            input logic [HA:0] pos);
        logic [HA:0] s;
        s = {1'b0, head} + pos;
        if (s >= (HA+1)'(HIGH_DEPTH)) s = s - (HA+1)'(HIGH_DEPTH);
        return s[HA-1:0];
    endfunction

    assign req.ready = (state_reg == S_IDLE) && !out_vld_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid    = out_vld_reg;
    assign rsp.accepted = out_reg.accepted;
    assign rsp.moved_up = out_reg.moved_up;
    assign rsp.next_id  = out_reg.next_id;

    logic req_fire;
    assign req_fire = req.valid && req.ready;

    // memory port controls, driven by the sequencer
    logic            hw_en, lw_en, pw_en;
    logic [HA-1:0]   hw_addr, hr_addr;
    logic [LA-1:0]   lw_addr, lr_addr;
    logic [PA-1:0]   pw_addr;
    logic [ID_W-1:0] hw_data, lw_data;

    always_ff @(posedge clk)
    begin
        if (hw_en) high_mem[hw_addr] <= hw_data;
        if (lw_en) low_mem[lw_addr] <= lw_data;
        if (pw_en) pend_mem[pw_addr] <= id_reg;
        hrd_reg <= high_mem[hr_addr];
        lrd_reg <= low_mem[lr_addr];
        prd_reg <= pend_mem[pidx_reg[PA-1:0]];
    end

    // derived decisions for the add paths
    logic high_room, low_room, low_under;
    assign high_room = high_count_reg < (HA+1)'(HIGH_DEPTH);
    assign low_room  = low_count_reg < (LA+1)'(LOW_DEPTH);
    assign low_under = 32'(low_count_reg) <= 32'(limit_reg);

    always_comb
    begin
        hw_en = 1'b0; lw_en = 1'b0; pw_en = 1'b0;
        hw_addr = hphys(high_head_reg, high_count_reg);
        hw_data = id_reg;
        lw_addr = lphys(low_head_reg, low_count_reg);
        lw_data = id_reg;
        pw_addr = free_slot_reg;
        hr_addr = high_head_reg;
        lr_addr = lphys(low_head_reg, lidx_reg);
        case (state_reg)
            S_DECIDE:
            begin
                if (id_ok_reg && !found_reg && free_reg)
                begin
                    if (kind_reg == tldq_pkg::KIND_ADD_HIGH && high_room)
                    begin
                        hw_en = 1'b1; pw_en = 1'b1;
                    end
                    else if (kind_reg == tldq_pkg::KIND_ADD_LOW && low_under && low_room)
                    begin
                        lw_en = 1'b1; pw_en = 1'b1;
                    end
                end
            end
            S_LCHK:
            begin
                // move found id to the high tail
                if (lrd_reg == id_reg && high_room) hw_en = 1'b1;
            end
            S_SHIFT_RD:
            begin
                lr_addr = lphys(low_head_reg, lidx_reg + (LA+1)'(1));
            end
            S_SHIFT_WR:
            begin
                lw_en = 1'b1;
                lw_addr = lphys(low_head_reg, lidx_reg);
                lw_data = lrd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pvalid_reg     <= '0;
            low_count_reg  <= '0;
            high_count_reg <= '0;
            high_head_reg  <= '0;
            low_head_reg   <= '0;
            limit_reg      <= tldq_pkg::LIMIT_RESET;
            out_vld_reg    <= 1'b0;
            kind_reg <= '0; id_reg <= '0; id_ok_reg <= 1'b0;
            pidx_reg <= '0; found_reg <= 1'b0; found_slot_reg <= '0;
            free_reg <= 1'b0; free_slot_reg <= '0;
            prd_vld_reg <= 1'b0; prd_slot_reg <= '0; lidx_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready) limit_reg <= cfg.data;
            if (rsp.valid && rsp.ready) out_vld_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        kind_reg  <= req.kind;
                        id_reg    <= req.user_id[ID_W-1:0];
                        id_ok_reg <= !req.user_id[31] && (req.user_id != 32'sd0);
                        pidx_reg  <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        prd_vld_reg <= 1'b0;
                        // low queue reads start from the head
                        lidx_reg  <= '0;
                        state_reg <= (req.kind == tldq_pkg::KIND_TAKE) ? S_TAKE_RD : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // compare the slot read last cycle, issue the next read
                    if (prd_vld_reg && pvalid_reg[prd_slot_reg] && prd_reg == id_reg
                        && !found_reg)
                    begin
                        found_reg <= 1'b1; found_slot_reg <= prd_slot_reg;
                    end
                    if (pidx_reg < (PA+1)'(PENDING_DEPTH))
                    begin
                        if (!pvalid_reg[pidx_reg[PA-1:0]] && !free_reg)
                        begin
                            free_reg <= 1'b1; free_slot_reg <= pidx_reg[PA-1:0];
                        end
                        prd_vld_reg  <= 1'b1;
                        prd_slot_reg <= pidx_reg[PA-1:0];
                        pidx_reg     <= pidx_reg + (PA+1)'(1);
                    end
                    else
                    begin
                        prd_vld_reg <= 1'b0;
                        state_reg   <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    out_reg.moved_up <= 1'b0;
                    out_reg.next_id  <= '0;
                    case (kind_reg)
                        tldq_pkg::KIND_ADD_HIGH:
                        begin
                            if (id_ok_reg && found_reg)
                            begin
                                out_reg.accepted <= 1'b0;
                                lidx_reg  <= '0;
                                state_reg <= S_LSCAN;
                            end
                            else if (id_ok_reg && free_reg && high_room)
                            begin
                                pvalid_reg[free_slot_reg] <= 1'b1;
                                high_count_reg <= high_count_reg + (HA+1)'(1);
                                out_reg.accepted <= 1'b1;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                out_reg.accepted <= 1'b0;
                                state_reg <= S_RESP;
                            end
                        end
                        tldq_pkg::KIND_ADD_LOW:
                        begin
                            state_reg <= S_RESP;
                            if (id_ok_reg && low_under && found_reg)
                                out_reg.accepted <= 1'b1;
                            else if (id_ok_reg && low_under && free_reg && low_room)
                            begin
                                pvalid_reg[free_slot_reg] <= 1'b1;
                                low_count_reg <= low_count_reg + (LA+1)'(1);
                                out_reg.accepted <= 1'b1;
                            end
                            else
                                out_reg.accepted <= 1'b0;
                        end
                        default:
                        begin
                            state_reg <= S_RESP;
                            if (id_ok_reg && found_reg)
                            begin
                                pvalid_reg[found_slot_reg] <= 1'b0;
                                out_reg.accepted <= 1'b1;
                            end
                            else
                                out_reg.accepted <= 1'b0;
                        end
                    endcase
                end
                S_LSCAN:
                begin
                    // read at lidx issued this cycle
                    if (lidx_reg < low_count_reg) state_reg <= S_LCHK;
                    else
                    begin
                        out_reg.accepted <= 1'b1;   // pending, not in low queue
                        state_reg <= S_RESP;
                    end
                end
                S_LCHK:
                begin
                    if (lrd_reg == id_reg)
                    begin
                        if (high_room)
                        begin
                            high_count_reg   <= high_count_reg + (HA+1)'(1);
                            out_reg.accepted <= 1'b1;
                            out_reg.moved_up <= 1'b1;
                            state_reg <= S_SHIFT_RD;
                        end
                        else state_reg <= S_RESP;
                    end
                    else
                    begin
                        lidx_reg  <= lidx_reg + (LA+1)'(1);
                        state_reg <= S_LSCAN;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (lidx_reg + (LA+1)'(1) < low_count_reg) state_reg <= S_SHIFT_WR;
                    else
                    begin
                        low_count_reg <= low_count_reg - (LA+1)'(1);
                        state_reg <= S_RESP;
                    end
                end
                S_SHIFT_WR:
                begin
                    lidx_reg  <= lidx_reg + (LA+1)'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_TAKE_RD:
                begin
                    // head reads issued; data lands next cycle
                    state_reg <= S_TAKE_WAIT;
                end
                S_TAKE_WAIT:
                begin
                    if (high_count_reg != '0)
                    begin
                        out_reg        <= {1'b1, 1'b0, hrd_reg};
                        high_count_reg <= high_count_reg - (HA+1)'(1);
                        high_head_reg  <= hphys(high_head_reg, (HA+1)'(1));
                    end
                    else if (low_count_reg != '0)
                    begin
                        out_reg       <= {1'b1, 1'b0, lrd_reg};
                        low_count_reg <= low_count_reg - (LA+1)'(1);
                        low_head_reg  <= lphys(low_head_reg, (LA+1)'(1));
                    end
                    else
                        out_reg <= '0;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    out_vld_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // counts never exceed their queue depths
    assert property (@(posedge clk) disable iff (!rst_n)
        high_count_reg <= (HA+1)'(HIGH_DEPTH) && low_count_reg <= (LA+1)'(LOW_DEPTH))
        else $error("queue count over depth");

    // a moved-up response is always an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.moved_up |-> rsp.accepted)
        else $error("moved_up without accepted");

    // a new item is never taken while a response is held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !req.ready)
        else $error("ready while response pending");

    // a refused response, such as a take of an empty pair of queues, hands out zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.accepted |-> rsp.next_id == '0)
        else $error("refused item carries an id");

endmodule
